// ===== src/tst_pkg.sv =====
// shared types and constants for the two-region slot table
`timescale 1ns / 1ps

package tst_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_BITS   = 6;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = 7;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_DELETE  = 2'd1,
        FUNC_ENABLE  = 2'd2,
        FUNC_DISABLE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE         = 2'd0,
        STAT_FULL         = 2'd1,
        STAT_NOT_OCCUPIED = 2'd2,
        STAT_ALREADY      = 2'd3
    } t_status;

    typedef struct packed {
        t_func                  func;
        logic [SLOT_BITS-1:0]   slot;
        logic [HANDLE_BITS-1:0] handle;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic                   moved;
        logic [HANDLE_BITS-1:0] moved_handle;
        logic [SLOT_BITS-1:0]   new_slot;
        logic [COUNT_BITS-1:0]  active_total;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic                   we;
        logic [SLOT_BITS-1:0]   waddr;
        logic [HANDLE_BITS-1:0] wdata;
        logic [SLOT_BITS-1:0]   raddr;
    } t_mem_req;

endpackage

// ===== src/tst_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tst_seq.sv =====
// operation sequencer: region bounds, store moves and result register
`timescale 1ns / 1ps

module tst_seq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  tst_pkg::t_in_item                     i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output tst_pkg::t_out_item                    o_out_data,
    output tst_pkg::t_mem_req                     o_mem_req,
    input  logic [tst_pkg::HANDLE_BITS-1:0]       i_mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_MOVE_A = 4'b0100,
        ST_MOVE_B = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic                                r_out_valid, n_out_valid;
    tst_pkg::t_out_item                  r_out, n_out;
    logic [tst_pkg::COUNT_BITS-1:0]      r_active, n_active;
    logic [tst_pkg::SLOT_BITS-1:0]       r_free, n_free;
    tst_pkg::t_func                      r_func, n_func;
    logic [tst_pkg::SLOT_BITS-1:0]       r_slot, n_slot;
    logic [tst_pkg::HANDLE_BITS-1:0]     r_handle, n_handle;
    logic [tst_pkg::SLOT_BITS-1:0]       r_src, n_src;
    logic [tst_pkg::SLOT_BITS-1:0]       r_dst, n_dst;
    logic                                r_single, n_single;

    logic                                out_free;
    logic                                emit;
    tst_pkg::t_out_item                  res;
    tst_pkg::t_mem_req                   mem_req;
    logic                                is_act, is_inact, full;
    logic [tst_pkg::COUNT_BITS-1:0]      act_m1;
    logic [tst_pkg::SLOT_BITS-1:0]       free_p1, free_m1, del_src;

    assign out_free = !r_out_valid || i_out_ready;
    assign act_m1   = r_active - tst_pkg::COUNT_BITS'(1);
    assign free_p1  = r_free + tst_pkg::SLOT_BITS'(1);
    assign free_m1  = r_free - tst_pkg::SLOT_BITS'(1);
    assign is_act   = {1'b0, r_slot} < r_active;
    assign is_inact = r_slot > r_free;
    assign full     = r_active >= {1'b0, r_free};
    assign del_src  = is_act ? act_m1[tst_pkg::SLOT_BITS-1:0] : free_p1;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_active    = r_active;
        n_free      = r_free;
        n_func      = r_func;
        n_slot      = r_slot;
        n_handle    = r_handle;
        n_src       = r_src;
        n_dst       = r_dst;
        n_single    = r_single;
        emit        = 1'b0;
        res         = '0;
        res.last    = 1'b1;
        mem_req       = '0;
        mem_req.raddr = r_src;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_in_data.func;
                    n_slot   = i_in_data.slot;
                    n_handle = i_in_data.handle;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                mem_req.raddr = (r_func == tst_pkg::FUNC_DELETE) ? del_src : r_slot;
                if (out_free) begin
                    n_state = ST_IDLE;
                    if (r_func == tst_pkg::FUNC_ADD) begin
                        emit = 1'b1;
                        if (full) begin
                            res.status = tst_pkg::STAT_FULL;
                        end else begin
                            mem_req.we     = 1'b1;
                            mem_req.waddr  = r_active[tst_pkg::SLOT_BITS-1:0];
                            mem_req.wdata  = r_handle;
                            res.moved      = 1'b1;
                            res.moved_handle = r_handle;
                            res.new_slot   = r_active[tst_pkg::SLOT_BITS-1:0];
                            n_active       = r_active + tst_pkg::COUNT_BITS'(1);
                        end
                    end else if (!is_act && !is_inact) begin
                        emit       = 1'b1;
                        res.status = tst_pkg::STAT_NOT_OCCUPIED;
                    end else begin
                        case (r_func)
                            tst_pkg::FUNC_DELETE: begin
                                if (is_act) begin
                                    n_active = act_m1;
                                end else begin
                                    n_free = free_p1;
                                end
                                if (del_src == r_slot) begin
                                    emit = 1'b1;
                                end else begin
                                    n_src   = del_src;
                                    n_state = ST_MOVE_B;
                                end
                            end
                            tst_pkg::FUNC_ENABLE: begin
                                if (is_act) begin
                                    emit       = 1'b1;
                                    res.status = tst_pkg::STAT_ALREADY;
                                end else begin
                                    n_dst    = r_active[tst_pkg::SLOT_BITS-1:0];
                                    n_src    = free_p1;
                                    n_single = (free_p1 == r_slot);
                                    n_active = r_active + tst_pkg::COUNT_BITS'(1);
                                    n_free   = free_p1;
                                    n_state  = ST_MOVE_A;
                                end
                            end
                            tst_pkg::FUNC_DISABLE: begin
                                if (is_inact) begin
                                    emit       = 1'b1;
                                    res.status = tst_pkg::STAT_ALREADY;
                                end else begin
                                    n_dst    = r_free;
                                    n_src    = act_m1[tst_pkg::SLOT_BITS-1:0];
                                    n_single = (act_m1[tst_pkg::SLOT_BITS-1:0] == r_slot);
                                    n_active = act_m1;
                                    n_free   = free_m1;
                                    n_state  = ST_MOVE_A;
                                end
                            end
                            default: begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_MOVE_A: begin
                mem_req.raddr = r_slot;
                if (out_free) begin
                    mem_req.raddr    = r_src;
                    mem_req.we       = 1'b1;
                    mem_req.waddr    = r_dst;
                    mem_req.wdata    = i_mem_rdata;
                    emit             = 1'b1;
                    res.moved        = 1'b1;
                    res.moved_handle = i_mem_rdata;
                    res.new_slot     = r_dst;
                    res.last         = r_single;
                    n_state          = r_single ? ST_IDLE : ST_MOVE_B;
                end
            end
            ST_MOVE_B: begin
                if (out_free) begin
                    mem_req.we       = 1'b1;
                    mem_req.waddr    = r_slot;
                    mem_req.wdata    = i_mem_rdata;
                    emit             = 1'b1;
                    res.moved        = 1'b1;
                    res.moved_handle = i_mem_rdata;
                    res.new_slot     = r_slot;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        res.active_total = n_active;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_free      <= tst_pkg::SLOT_BITS'(tst_pkg::SLOTS - 1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
            r_free      <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_func   <= n_func;
        r_slot   <= n_slot;
        r_handle <= n_handle;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_single <= n_single;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_mem_req   = mem_req;

endmodule

// ===== src/two_region_slot_table.sv =====
// top level of the two-region slot table
//
// a store of 64 handles kept as dense active slots at the front, a free gap,
// and dense inactive slots at the back; one free slot is always kept
// input channel (i_in_valid / o_in_ready / i_in_data) carries one operation:
// add a handle, delete, enable or disable a slot
// output channel (o_out_valid / i_out_ready / o_out_data) returns one or two
// result transactions per operation; every handle that lands at a new slot
// is reported, and the final transaction of an operation has last set
// order of steps: after accept the sequencer decodes the operation in ST_DECODE;
// add, errors and deletes without a move register their result there, a delete
// that moves registers it in ST_MOVE_B, and enable or disable register one
// result in ST_MOVE_A and, for a two-move operation, the second in ST_MOVE_B
// a new operation is accepted only after the previous one has finished; the
// single read port of the store reads one entry per cycle
// while the receiver stalls, the sequencer holds in its current step and
// o_in_ready stays low until the operation finishes
// reset: synchronous, active low; no active slots, all slots free, the
// store contents are left as they are
`timescale 1ns / 1ps

module two_region_slot_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tst_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tst_pkg::t_out_item o_out_data
);

    tst_pkg::t_mem_req               mem_req;
    logic [tst_pkg::HANDLE_BITS-1:0] mem_rdata;

    tst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    tst_ram #(
        .WIDTH (tst_pkg::HANDLE_BITS),
        .DEPTH (tst_pkg::SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule
